// ===== rtl/core/depq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depq_pkg
// Types and constants shared by the double-ended priority queue cells and top.
// ----------------------------------------------------------------------------
package depq_pkg;

  localparam int CAPACITY      = 16;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP_MAX = 2'd1,
    CMD_POP_MIN = 2'd2
  } depq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } depq_status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] priority_req;
    logic [15:0]        payload;
  } depq_in_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [15:0]         removed_priority;
    logic [15:0]                removed_payload;
    logic signed [15:0]         max_priority;
    logic [15:0]                max_payload;
    logic signed [15:0]         min_priority;
    logic [15:0]                min_payload;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } depq_out_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] prio;
    logic [15:0]        data;
  } depq_entry_t;

  typedef struct packed {
    logic               insert;
    logic               pop_max;
    logic               pop_min;
    logic signed [15:0] prio;
    logic [15:0]        data;
  } depq_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/depq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depq_cell
// One slot of the sorted shift chain. By the operation broadcast it keeps its
// entry, takes the new one or a neighbor's, or drops its own if it is the last.
// ----------------------------------------------------------------------------
module depq_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire depq_pkg::depq_ctl_t   ctl,
  input  wire depq_pkg::depq_entry_t left_entry,
  input  wire logic                 left_keep,
  input  wire depq_pkg::depq_entry_t right_entry,
  output depq_pkg::depq_entry_t      entry,
  output logic                       keep,
  output logic                       is_last
);
  import depq_pkg::*;

  depq_entry_t entry_r;
  depq_entry_t entry_nxt;

  assign entry   = entry_r;
  assign keep    = entry_r.valid && (entry_r.prio >= ctl.prio);
  assign is_last = entry_r.valid && !right_entry.valid;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          entry_nxt.valid = 1'b1;
          entry_nxt.prio  = ctl.prio;
          entry_nxt.data  = ctl.data;
        end else begin
          entry_nxt = left_entry;
        end
      end
    end else if (ctl.pop_max) begin
      entry_nxt = right_entry;
    end else if (ctl.pop_min) begin
      entry_nxt.valid = entry_r.valid && !is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.prio <= entry_nxt.prio;
    entry_r.data <= entry_nxt.data;
  end

endmodule
`default_nettype wire

// ===== rtl/core/double_ended_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded queue of signed Q8.8 priorities with data, sorted highest first.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one command word:
//   insert, remove highest or remove lowest. Each word yields exactly one
//   result word on the output channel (out_valid, out_ready, out_data) with
//   the status, the removed entry, and the maximum, minimum and count after
//   the operation.
//   The entries sit in a chain of cells that all compare against the new
//   priority at once and shift by one place. The chain updates at the edge
//   that accepts a word; the result register loads once the output register
//   is free, and no new word is accepted while a result is still waiting to
//   load, so a word is taken only after the last one's result has loaded.
//   If the receiver stalls, one finished result waits in the output register
//   while the next word is still accepted and processed; further words wait
//   until the output register drains.
//   Reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module double_ended_priority_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire depq_pkg::depq_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output depq_pkg::depq_out_t      out_data
);
  import depq_pkg::*;

  depq_entry_t cell_q [CAPACITY];
  logic        keep_q [CAPACITY];
  logic        last_q [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] last_vec;

  depq_ctl_t   ctl;
  depq_entry_t last_entry;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 load;
  logic [1:0]           status;

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 pend_r;
  logic [1:0]           stat_r;
  logic signed [15:0]   rem_prio_r;
  logic [15:0]          rem_data_r;
  logic signed [15:0]   rem_prio_nxt;
  logic [15:0]          rem_data_nxt;
  logic                 out_valid_r;
  depq_out_t            out_r;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      depq_entry_t left_e;
      depq_entry_t right_e;
      logic        left_k;
      if (gi == 0) begin : g_head
        assign left_e = '0;
        assign left_k = 1'b1;
      end else begin : g_body
        assign left_e = cell_q[gi-1];
        assign left_k = keep_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign right_e = '0;
      end else begin : g_next
        assign right_e = cell_q[gi+1];
      end
      depq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .left_entry  (left_e),
        .left_keep   (left_k),
        .right_entry (right_e),
        .entry       (cell_q[gi]),
        .keep        (keep_q[gi]),
        .is_last     (last_q[gi])
      );
      assign valid_vec[gi] = cell_q[gi].valid;
      assign last_vec[gi]  = last_q[gi];
    end
  endgenerate

  assign in_ready = !pend_r;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign load     = pend_r && (!out_valid_r || out_ready);

  always_comb begin
    last_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (last_q[i]) begin
        last_entry = last_entry | cell_q[i];
      end
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.prio     = in_data.priority_req;
    ctl.data     = in_data.payload;
    status       = ST_OK;
    rem_prio_nxt = '0;
    rem_data_nxt = '0;
    count_nxt    = count_r;
    case (in_data.command)
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.insert = accept;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_POP_MAX: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.pop_max  = accept;
          rem_prio_nxt = cell_q[0].prio;
          rem_data_nxt = cell_q[0].data;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      CMD_POP_MIN: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.pop_min  = accept;
          rem_prio_nxt = last_entry.prio;
          rem_data_nxt = last_entry.data;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        pend_r  <= 1'b1;
      end else if (load) begin
        pend_r  <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r     <= status;
      rem_prio_r <= rem_prio_nxt;
      rem_data_r <= rem_data_nxt;
    end
    if (load) begin
      out_r.status           <= stat_r;
      out_r.removed_priority <= rem_prio_r;
      out_r.removed_payload  <= rem_data_r;
      out_r.max_priority     <= cell_q[0].valid ? cell_q[0].prio : '0;
      out_r.max_payload      <= cell_q[0].valid ? cell_q[0].data : '0;
      out_r.min_priority     <= last_entry.prio;
      out_r.min_payload      <= last_entry.data;
      out_r.entry_count      <= ENTRY_COUNT_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_matches_cells : assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_vec)))
    else $error("entry count differs from the number of occupied cells");

  a_cells_packed : assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
    else $error("occupied cells are not packed toward the head");

  a_single_tail : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(last_vec))
    else $error("more than one cell claims to hold the lowest entry");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_accept_sets_pending : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pend_r && !in_ready)
    else $error("accepted word did not leave a pending result");
`endif

endmodule
`default_nettype wire

// ===== verif/double_ended_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_tb
// Self-checking bench for the double-ended priority queue. A sorted model in
// the bench predicts every result word. Directed tests cover empty removals,
// priority extremes, ties and single-entry removals. Random phases fill,
// churn and drain the queue while both channels idle at random.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_tb;
  import depq_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int END_SETTLE = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  depq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  depq_out_t out_data;

  double_ended_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Sorted copy of the queue, highest priority at index 0.
  logic signed [15:0] sorted_prio[CAPACITY];
  logic [15:0] sorted_data[CAPACITY];
  int held = 0;

  depq_out_t pending_results[$];
  int mismatches = 0;
  int words_checked = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int n_insert = 0;
  int n_pop = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_nop = 0;
  int peak_held = 0;

  function automatic depq_out_t apply_command(depq_in_t w);
    depq_out_t r;
    int pos;
    int i;
    r = '0;
    r.status = ST_OK;
    case (w.command)
      CMD_INSERT: begin
        n_insert++;
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held && sorted_prio[pos] >= $signed(w.priority_req)) pos++;
          for (i = held; i > pos; i--) begin
            sorted_prio[i] = sorted_prio[i-1];
            sorted_data[i] = sorted_data[i-1];
          end
          sorted_prio[pos] = w.priority_req;
          sorted_data[pos] = w.payload;
          held++;
        end
      end
      CMD_POP_MAX: begin
        n_pop++;
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_priority = sorted_prio[0];
          r.removed_payload = sorted_data[0];
          for (i = 1; i < held; i++) begin
            sorted_prio[i-1] = sorted_prio[i];
            sorted_data[i-1] = sorted_data[i];
          end
          held--;
        end
      end
      CMD_POP_MIN: begin
        n_pop++;
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_priority = sorted_prio[held-1];
          r.removed_payload = sorted_data[held-1];
          held--;
        end
      end
      default: n_nop++;
    endcase
    if (held > 0) begin
      r.max_priority = sorted_prio[0];
      r.max_payload = sorted_data[0];
      r.min_priority = sorted_prio[held-1];
      r.min_payload = sorted_data[held-1];
    end
    r.entry_count = ENTRY_COUNT_W'(held);
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
    if (held > peak_held) peak_held = held;
    return r;
  endfunction

  task automatic check_word(depq_out_t got);
    depq_out_t want;
    bit bad;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result word %h", got);
      return;
    end
    want = pending_results.pop_front();
    words_checked++;
    bad = (got.status !== want.status) ||
          (got.removed_priority !== want.removed_priority) ||
          (got.removed_payload !== want.removed_payload) ||
          (got.max_priority !== want.max_priority) ||
          (got.max_payload !== want.max_payload) ||
          (got.min_priority !== want.min_priority) ||
          (got.min_payload !== want.min_payload) ||
          (got.entry_count !== want.entry_count);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: word %0d st %0d/%0d rem %h:%h/%h:%h max %h:%h/%h:%h",
                 words_checked, got.status, want.status,
                 got.removed_priority, got.removed_payload,
                 want.removed_priority, want.removed_payload,
                 got.max_priority, got.max_payload,
                 want.max_priority, want.max_payload);
        $display("       min %h:%h/%h:%h count %0d/%0d",
                 got.min_priority, got.min_payload,
                 want.min_priority, want.min_payload,
                 got.entry_count, want.entry_count);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_word(out_data);
      if (in_valid && in_ready) pending_results.push_back(apply_command(in_data));
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_steady || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                  : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: run timed out with %0d results outstanding",
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic depq_in_t make_word(logic [1:0] cmd, logic [15:0] prio,
                                         logic [15:0] data);
    depq_in_t w;
    w.command = cmd;
    w.priority_req = prio;
    w.payload = data;
    return w;
  endfunction

  function automatic logic [15:0] random_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return {8'($urandom_range(0, 4) - 2), 8'h00};
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic depq_in_t random_word(int insert_pct);
    int r;
    logic [1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 2) cmd = CMD_NOP;
    else if (r < insert_pct) cmd = CMD_INSERT;
    else if ($urandom_range(0, 1) == 0) cmd = CMD_POP_MAX;
    else cmd = CMD_POP_MIN;
    return make_word(cmd, random_priority(), 16'($urandom));
  endfunction

  task automatic send_word(depq_in_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_removals();
    send_word(make_word(CMD_POP_MAX, 16'h1234, 16'h5678));
    send_word(make_word(CMD_POP_MIN, 16'hffff, 16'hffff));
    send_word(make_word(CMD_NOP, 16'h0000, 16'h0000));
  endtask

  task automatic test_extremes();
    send_word(make_word(CMD_INSERT, 16'h7fff, 16'hffff));
    send_word(make_word(CMD_INSERT, 16'h8000, 16'h0000));
    send_word(make_word(CMD_INSERT, 16'h0000, 16'haaaa));
    send_word(make_word(CMD_NOP, 16'hffff, 16'h5555));
    send_word(make_word(CMD_POP_MAX, 16'h0000, 16'h0000));
    send_word(make_word(CMD_POP_MIN, 16'h0000, 16'h0000));
    send_word(make_word(CMD_POP_MIN, 16'h0000, 16'h0000));
    send_word(make_word(CMD_INSERT, 16'hffff, 16'h1111));
    send_word(make_word(CMD_POP_MAX, 16'h0000, 16'h0000));
  endtask

  task automatic test_equal_priorities();
    send_word(make_word(CMD_INSERT, 16'h0100, 16'ha001));
    send_word(make_word(CMD_INSERT, 16'h0100, 16'ha002));
    send_word(make_word(CMD_INSERT, 16'h0100, 16'ha003));
    send_word(make_word(CMD_POP_MIN, 16'h0000, 16'h0000));
    send_word(make_word(CMD_POP_MAX, 16'h0000, 16'h0000));
    send_word(make_word(CMD_INSERT, 16'h0100, 16'ha004));
    send_word(make_word(CMD_POP_MIN, 16'h0000, 16'h0000));
    send_word(make_word(CMD_POP_MAX, 16'h0000, 16'h0000));
    send_word(make_word(CMD_POP_MIN, 16'h0000, 16'h0000));
  endtask

  // Runs past capacity on both ends so full statuses show up with a crowded
  // store behind them, and empty statuses once the store has been drained.
  task automatic test_fill_and_overflow();
    int i;
    for (i = 0; i < CAPACITY + 4; i++) send_word(random_word(100));
    wait_drained();
    for (i = 0; i < CAPACITY + 4; i++) begin
      send_word(make_word(($urandom_range(0, 1) == 0) ? CMD_POP_MAX : CMD_POP_MIN,
                          16'($urandom), 16'($urandom)));
    end
  endtask

  task automatic test_random_mix();
    int phase;
    int i;
    int insert_pct;
    for (phase = 0; phase < 16; phase++) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      case (phase % 3)
        0: insert_pct = 80;
        1: insert_pct = 52;
        default: insert_pct = 25;
      endcase
      for (i = 0; i < 40; i++) send_word(random_word(insert_pct));
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_removals();
    test_extremes();
    test_equal_priorities();
    wait_drained();
    test_fill_and_overflow();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    $display("Checked %0d words: %0d inserts, %0d removals, %0d no-ops.",
             words_checked, n_insert, n_pop, n_nop);
    $display("Saw %0d full and %0d empty statuses, peak occupancy %0d.",
             n_full, n_empty, peak_held);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("Mismatching words: %0d", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/depq_pkg.sv
rtl/core/depq_cell.sv
rtl/core/double_ended_priority_queue.sv
verif/double_ended_priority_queue_tb.sv
